// ----- design/wsd_pkg.sv -----
// Shared types and constants for the waypoint steering decider.
package wsd_pkg;

    localparam int COORD_W   = 12;
    localparam int IDX_W     = 6;
    localparam int PTR_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int OPND_W    = 27;
    localparam int PROD_W    = 51;
    localparam int SQ_W      = 2 * COORD_W + 1;
    localparam int STEP_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LATERAL_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYPOINT_COUNT = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_RIGHT = 3'd2,
        CMD_LEFT  = 3'd3,
        CMD_FWD   = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        OPD_DX23, OPD_DY23, OPD_DX12, OPD_DY12, OPD_DX13, OPD_DY13,
        OPD_RAD, OPD_LAT, OPD_CROSS, OPD_D12, OPD_LSQ
    } opnd_t;

    typedef enum logic [2:0] {
        DST_D23, DST_RSQ, DST_D12, DST_CROSS, DST_DOT, DST_LSQ, DST_CRSQ, DST_RHS
    } dst_t;

    typedef enum logic [1:0] {
        ACC_LOAD, ACC_ADD, ACC_SUB
    } acc_op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FETCH, ST_MUL_A, ST_WAIT_A, ST_ARRIVE, ST_MUL_B, ST_WAIT_B,
        ST_EMIT_DONE, ST_EMIT_ARR, ST_EMIT_MOVE, ST_EMIT_FWD
    } state_t;

    typedef struct packed {
        logic    en;
        opnd_t   a;
        opnd_t   b;
        dst_t    dst;
        acc_op_t op;
    } mul_cmd_t;

    typedef struct packed {
        logic     wp_write;
        logic     pose_load;
        logic     diff_load;
        mul_cmd_t mul;
        logic     ptr_inc;
        logic     out_load;
        cmd_t     out_cmd;
        logic     out_reached;
        logic     out_done;
        logic     out_last;
    } ctl_t;

    typedef struct packed {
        logic route_done;
        logic arrive;
        logic turn_needed;
        logic cross_pos;
        logic dot_neg;
        logic out_free;
    } stat_t;

endpackage

// ----- design/wsd_ctrl.sv -----
// Sequencer for the waypoint steering decider: handshake, multiply schedule, result emission.
module wsd_ctrl import wsd_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  s_action,
    output logic  s_ready,
    input  stat_t stat,
    output ctl_t  ctl
);

    localparam logic [STEP_W-1:0] STEP_A_LAST = 4'd2;
    localparam logic [STEP_W-1:0] STEP_B_LAST = 4'd11;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              accept;
    cmd_t              turn_cmd;

    // multiply schedule: distance to goal and radius first, then the heading tests
    function automatic mul_cmd_t step_op(input logic [STEP_W-1:0] step);
        mul_cmd_t m;
        m = '{en: 1'b1, a: OPD_DX23, b: OPD_DX23, dst: DST_D23, op: ACC_LOAD};
        unique case (step)
            4'd0:  m = '{en: 1'b1, a: OPD_DX23,  b: OPD_DX23,  dst: DST_D23,   op: ACC_LOAD};
            4'd1:  m = '{en: 1'b1, a: OPD_DY23,  b: OPD_DY23,  dst: DST_D23,   op: ACC_ADD};
            4'd2:  m = '{en: 1'b1, a: OPD_RAD,   b: OPD_RAD,   dst: DST_RSQ,   op: ACC_LOAD};
            4'd3:  m = '{en: 1'b1, a: OPD_DX12,  b: OPD_DX12,  dst: DST_D12,   op: ACC_LOAD};
            4'd4:  m = '{en: 1'b1, a: OPD_DY12,  b: OPD_DY12,  dst: DST_D12,   op: ACC_ADD};
            4'd5:  m = '{en: 1'b1, a: OPD_DX12,  b: OPD_DY13,  dst: DST_CROSS, op: ACC_LOAD};
            4'd6:  m = '{en: 1'b1, a: OPD_DX13,  b: OPD_DY12,  dst: DST_CROSS, op: ACC_SUB};
            4'd7:  m = '{en: 1'b1, a: OPD_DX13,  b: OPD_DX12,  dst: DST_DOT,   op: ACC_LOAD};
            4'd8:  m = '{en: 1'b1, a: OPD_DY13,  b: OPD_DY12,  dst: DST_DOT,   op: ACC_ADD};
            4'd9:  m = '{en: 1'b1, a: OPD_LAT,   b: OPD_LAT,   dst: DST_LSQ,   op: ACC_LOAD};
            4'd10: m = '{en: 1'b1, a: OPD_CROSS, b: OPD_CROSS, dst: DST_CRSQ,  op: ACC_LOAD};
            4'd11: m = '{en: 1'b1, a: OPD_LSQ,   b: OPD_D12,   dst: DST_RHS,   op: ACC_LOAD};
            default: m.en = 1'b0;
        endcase
        return m;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_action) begin
                    state_next = stat.route_done ? ST_EMIT_DONE : ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_MUL_A;
                step_next  = '0;
            end
            ST_MUL_A: begin
                step_next = step_reg + 4'd1;
                if (step_reg == STEP_A_LAST) begin
                    state_next = ST_WAIT_A;
                end
            end
            ST_WAIT_A: state_next = ST_ARRIVE;
            ST_ARRIVE: state_next = stat.arrive ? ST_EMIT_ARR : ST_MUL_B;
            ST_MUL_B: begin
                step_next = step_reg + 4'd1;
                if (step_reg == STEP_B_LAST) begin
                    state_next = ST_WAIT_B;
                end
            end
            ST_WAIT_B: state_next = ST_EMIT_MOVE;
            ST_EMIT_DONE, ST_EMIT_ARR, ST_EMIT_FWD: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_MOVE: begin
                if (stat.out_free) begin
                    state_next = (!stat.turn_needed && stat.dot_neg) ? ST_EMIT_FWD : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign accept   = s_valid && s_ready;
    assign turn_cmd = stat.cross_pos ? CMD_RIGHT : CMD_LEFT;

    // outputs
    always_comb begin
        s_ready         = 1'b0;
        ctl             = '0;
        ctl.mul.en      = 1'b0;
        ctl.out_cmd     = CMD_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                ctl.wp_write  = accept && !s_action;
                ctl.pose_load = accept && s_action;
            end
            ST_FETCH:  ctl.diff_load = 1'b1;
            ST_MUL_A, ST_MUL_B: ctl.mul = step_op(step_reg);
            ST_WAIT_A, ST_WAIT_B: ctl.mul.en = 1'b0;
            ST_ARRIVE: ctl.ptr_inc = stat.arrive;
            ST_EMIT_DONE: begin
                ctl.out_load = stat.out_free;
                ctl.out_cmd  = CMD_STOP;
                ctl.out_done = 1'b1;
                ctl.out_last = 1'b1;
            end
            ST_EMIT_ARR: begin
                // pointer has already moved; route_done reflects the new goal
                ctl.out_load    = stat.out_free;
                ctl.out_cmd     = stat.route_done ? CMD_STOP : CMD_NONE;
                ctl.out_reached = 1'b1;
                ctl.out_done    = stat.route_done;
                ctl.out_last    = 1'b1;
            end
            ST_EMIT_MOVE: begin
                ctl.out_load = stat.out_free;
                if (stat.turn_needed) begin
                    ctl.out_cmd  = turn_cmd;
                    ctl.out_last = 1'b1;
                end else if (stat.dot_neg) begin
                    ctl.out_cmd  = turn_cmd;
                    ctl.out_last = 1'b0;
                end else begin
                    ctl.out_cmd  = CMD_FWD;
                    ctl.out_last = 1'b1;
                end
            end
            ST_EMIT_FWD: begin
                ctl.out_load = stat.out_free;
                ctl.out_cmd  = CMD_FWD;
                ctl.out_last = 1'b1;
            end
            default: s_ready = 1'b0;
        endcase
    end

endmodule

// ----- design/wsd_datapath.sv -----
// Datapath: waypoint memory, config registers, shared multiplier, accumulators, result register.
module wsd_datapath import wsd_pkg::*; #(
    parameter int MAX_WAYPOINTS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_wdata,
    input  logic [COORD_W-1:0]   s_head_x,
    input  logic [COORD_W-1:0]   s_head_y,
    input  logic [COORD_W-1:0]   s_tail_x,
    input  logic [COORD_W-1:0]   s_tail_y,
    input  logic [IDX_W-1:0]     s_wp_index,
    input  logic [COORD_W-1:0]   s_wp_x,
    input  logic [COORD_W-1:0]   s_wp_y,
    input  ctl_t                 ctl,
    output stat_t                stat,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [2:0]           m_command,
    output logic                 m_goal_reached,
    output logic                 m_route_done,
    output logic [PTR_W-1:0]     m_goal_index,
    output logic                 m_last
);

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = ((AW > PTR_W) ? AW : PTR_W) + 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_WAYPOINTS);

    // configuration
    logic [COORD_W-1:0] radius_reg, limit_reg;
    logic [PTR_W-1:0]   count_reg;
    logic [PTR_W-1:0]   ptr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 12'd20;
            limit_reg  <= 12'd10;
            count_reg  <= 7'd1;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_ARRIVAL_RADIUS) radius_reg <= cfg_wdata;
            if (cfg_index == REG_LATERAL_LIMIT)  limit_reg  <= cfg_wdata;
            if (cfg_index == REG_WAYPOINT_COUNT) count_reg  <= cfg_wdata[PTR_W-1:0];
        end
    end

    // goal pointer and route status
    logic [CW-1:0] cnt_wide, cnt_eff, ptr_wide, wr_wide;
    logic          wr_in_range;
    logic [AW-1:0] rd_addr, wr_addr;

    assign cnt_wide        = CW'(count_reg);
    assign cnt_eff         = (cnt_wide > MAX_C) ? MAX_C : cnt_wide;
    assign ptr_wide        = CW'(ptr_reg);
    assign stat.route_done = ptr_wide >= cnt_eff;
    assign rd_addr         = ptr_wide[AW-1:0];
    assign wr_wide         = CW'(s_wp_index);
    assign wr_in_range     = wr_wide < MAX_C;
    assign wr_addr         = wr_wide[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (ctl.ptr_inc) begin
            ptr_reg <= ptr_reg + 7'd1;
        end
    end

    // waypoint store, {x, y}
    logic [2*COORD_W-1:0] wp_mem [MAX_WAYPOINTS];
    logic [2*COORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wp_write && wr_in_range) begin
            wp_mem[wr_addr] <= {s_wp_x, s_wp_y};
        end
        rd_data_reg <= wp_mem[rd_addr];
    end

    // pose and coordinate differences
    logic [COORD_W-1:0] head_x_reg, head_y_reg, tail_x_reg, tail_y_reg;
    logic [COORD_W-1:0] goal_x, goal_y;
    logic signed [DIFF_W-1:0] dx23_reg, dy23_reg, dx12_reg, dy12_reg, dx13_reg, dy13_reg;
    logic signed [DIFF_W-1:0] dx23_next, dy23_next, dx12_next, dy12_next, dx13_next, dy13_next;

    assign goal_x    = rd_data_reg[2*COORD_W-1:COORD_W];
    assign goal_y    = rd_data_reg[COORD_W-1:0];
    assign dx23_next = $signed({1'b0, goal_x}) - $signed({1'b0, head_x_reg});
    assign dy23_next = $signed({1'b0, goal_y}) - $signed({1'b0, head_y_reg});
    assign dx12_next = $signed({1'b0, head_x_reg}) - $signed({1'b0, tail_x_reg});
    assign dy12_next = $signed({1'b0, head_y_reg}) - $signed({1'b0, tail_y_reg});
    assign dx13_next = $signed({1'b0, goal_x}) - $signed({1'b0, tail_x_reg});
    assign dy13_next = $signed({1'b0, goal_y}) - $signed({1'b0, tail_y_reg});

    always_ff @(posedge aclk) begin
        if (ctl.pose_load) begin
            head_x_reg <= s_head_x;
            head_y_reg <= s_head_y;
            tail_x_reg <= s_tail_x;
            tail_y_reg <= s_tail_y;
        end
        if (ctl.diff_load) begin
            dx23_reg <= dx23_next;
            dy23_reg <= dy23_next;
            dx12_reg <= dx12_next;
            dy12_reg <= dy12_next;
            dx13_reg <= dx13_next;
            dy13_reg <= dy13_next;
        end
    end

    // accumulated quantities
    logic signed [OPND_W-1:0] d23_reg, d12_reg, cross_reg, dot_reg;
    logic signed [SQ_W-1:0]   rsq_reg, lsq_reg;
    logic signed [PROD_W-1:0] crsq_reg, rhs_reg;

    function automatic logic signed [OPND_W-1:0] pick(input opnd_t sel);
        logic signed [OPND_W-1:0] v;
        v = '0;
        unique case (sel)
            OPD_DX23:  v = OPND_W'(dx23_reg);
            OPD_DY23:  v = OPND_W'(dy23_reg);
            OPD_DX12:  v = OPND_W'(dx12_reg);
            OPD_DY12:  v = OPND_W'(dy12_reg);
            OPD_DX13:  v = OPND_W'(dx13_reg);
            OPD_DY13:  v = OPND_W'(dy13_reg);
            OPD_RAD:   v = OPND_W'({1'b0, radius_reg});
            OPD_LAT:   v = OPND_W'({1'b0, limit_reg});
            OPD_CROSS: v = cross_reg;
            OPD_D12:   v = d12_reg;
            OPD_LSQ:   v = OPND_W'(lsq_reg);
            default:   v = '0;
        endcase
        return v;
    endfunction

    // multiply stage
    logic signed [OPND_W-1:0]   op_a, op_b;
    logic signed [2*OPND_W-1:0] prod_full;
    logic signed [PROD_W-1:0]   p_reg;
    logic                       acc_en_reg;
    dst_t                       dst_reg;
    acc_op_t                    acc_op_reg;

    always_comb begin
        op_a = pick(ctl.mul.a);
        op_b = pick(ctl.mul.b);
    end

    assign prod_full = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg <= 1'b0;
        end else begin
            acc_en_reg <= ctl.mul.en;
        end
        p_reg      <= prod_full[PROD_W-1:0];
        dst_reg    <= ctl.mul.dst;
        acc_op_reg <= ctl.mul.op;
    end

    // accumulate stage
    logic signed [OPND_W-1:0] acc_base, acc_p, acc_sum;

    assign acc_p = $signed(p_reg[OPND_W-1:0]);

    always_comb begin
        unique case (dst_reg)
            DST_D23:   acc_base = d23_reg;
            DST_D12:   acc_base = d12_reg;
            DST_CROSS: acc_base = cross_reg;
            DST_DOT:   acc_base = dot_reg;
            default:   acc_base = '0;
        endcase
        unique case (acc_op_reg)
            ACC_ADD: acc_sum = acc_base + acc_p;
            ACC_SUB: acc_sum = acc_base - acc_p;
            default: acc_sum = acc_p;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (acc_en_reg) begin
            unique case (dst_reg)
                DST_D23:   d23_reg   <= acc_sum;
                DST_D12:   d12_reg   <= acc_sum;
                DST_CROSS: cross_reg <= acc_sum;
                DST_DOT:   dot_reg   <= acc_sum;
                DST_RSQ:   rsq_reg   <= p_reg[SQ_W-1:0];
                DST_LSQ:   lsq_reg   <= p_reg[SQ_W-1:0];
                DST_CRSQ:  crsq_reg  <= p_reg;
                DST_RHS:   rhs_reg   <= p_reg;
            endcase
        end
    end

    assign stat.arrive      = d23_reg < OPND_W'(rsq_reg);
    assign stat.turn_needed = crsq_reg > rhs_reg;
    assign stat.cross_pos   = cross_reg > 0;
    assign stat.dot_neg     = dot_reg[OPND_W-1];

    // result register
    logic             m_valid_reg;
    cmd_t             m_command_reg;
    logic             m_reached_reg, m_done_reg, m_last_reg;
    logic [PTR_W-1:0] m_index_reg;

    assign stat.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (ctl.out_load) begin
            m_command_reg <= ctl.out_cmd;
            m_reached_reg <= ctl.out_reached;
            m_done_reg    <= ctl.out_done;
            m_last_reg    <= ctl.out_last;
            m_index_reg   <= ptr_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_command      = m_command_reg;
    assign m_goal_reached = m_reached_reg;
    assign m_route_done   = m_done_reg;
    assign m_goal_index   = m_index_reg;
    assign m_last         = m_last_reg;

endmodule

// ----- design/waypoint_steering_decider.sv -----
// Top level of the waypoint steering decider.
// Load items (action 0) write one waypoint; no result follows.
// A pose item (action 1) is scored against the current goal with one shared 27x27
// multiplier that forms twelve products in turn: the arrival test comes first and the
// full turn/behind test after it, and a pose item gives one result item or two. Once
// the route is done a pose gives stop. The next item is taken as soon as the last
// result is in the output register, even if it is still waiting.
module waypoint_steering_decider import wsd_pkg::*; #(
    parameter int MAX_WAYPOINTS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [COORD_W-1:0]   s_head_x,
    input  logic [COORD_W-1:0]   s_head_y,
    input  logic [COORD_W-1:0]   s_tail_x,
    input  logic [COORD_W-1:0]   s_tail_y,
    input  logic [IDX_W-1:0]     s_wp_index,
    input  logic [COORD_W-1:0]   s_wp_x,
    input  logic [COORD_W-1:0]   s_wp_y,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_command,
    output logic                 m_goal_reached,
    output logic                 m_route_done,
    output logic [PTR_W-1:0]     m_goal_index,
    output logic                 m_last
);

    ctl_t  ctl;
    stat_t stat;

    wsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    wsd_datapath #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_head_x       (s_head_x),
        .s_head_y       (s_head_y),
        .s_tail_x       (s_tail_x),
        .s_tail_y       (s_tail_y),
        .s_wp_index     (s_wp_index),
        .s_wp_x         (s_wp_x),
        .s_wp_y         (s_wp_y),
        .ctl            (ctl),
        .stat           (stat),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_command      (m_command),
        .m_goal_reached (m_goal_reached),
        .m_route_done   (m_route_done),
        .m_goal_index   (m_goal_index),
        .m_last         (m_last)
    );

endmodule

// ----- design/wsd_checker.sv -----
// Port-level checks for the waypoint steering decider, bound to the top level.
module wsd_checker import wsd_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             s_action,
    input logic             m_valid,
    input logic             m_ready,
    input logic [2:0]       m_command,
    input logic             m_goal_reached,
    input logic             m_route_done,
    input logic [PTR_W-1:0] m_goal_index,
    input logic             m_last
);

    // a waiting result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_command) && $stable(m_last)
            && $stable(m_goal_index))
        else $error("result item changed while stalled");

    // the block is not ready in the cycle after a pose item is taken
    a_pose_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action |=> !s_ready)
        else $error("input taken straight after a pose item");

    a_done_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_route_done |-> m_command == CMD_STOP && m_last)
        else $error("route done without a final stop");

    a_reached_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_goal_reached && !m_route_done |-> m_command == CMD_NONE && m_last)
        else $error("goal reached mid-route with a command");

    // only the turn ahead of a forward may be non-final
    a_first_of_two: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> (m_command == CMD_RIGHT || m_command == CMD_LEFT)
            && !m_goal_reached && !m_route_done)
        else $error("unexpected non-final result item");

endmodule

bind waypoint_steering_decider wsd_checker u_wsd_checker (.*);
